// ===== design/bfr_pkg.sv =====
// Shared types and constants of the bicubic resample pass.
// Field widths, request codes, sequencer states and the MAC control bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned LPOS_W   = 12;
    localparam int unsigned OPOS_W   = 11;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned TAPP_W   = 4;
    localparam int unsigned WGT_W    = 24;
    localparam int unsigned WIN_W    = LPOS_W + CNT_W;
    localparam int unsigned SRC_W    = LPOS_W + 1;
    localparam int unsigned PROD_W   = PIX_W + 1 + WGT_W;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [1:0] {
        FUNC_PIXEL   = 2'd0,
        FUNC_WINDOW  = 2'd1,
        FUNC_WEIGHT  = 2'd2,
        FUNC_COMPUTE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_TAP,
        ST_DRAIN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic tap_valid;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bicubic_fixed_point_resample.sv =====
// One 1-D pass of a separable bicubic resampler in fixed point.
// Input channel (s_valid/s_ready) carries one request per transfer, selected
// by s_func: pixel write, window write, weight write or compute. Writes go to
// the line store, window table or weight table and finish without leaving
// the idle state, so write requests stream back to back. A compute request
// reads its window, then walks its taps through one multiply-accumulate
// unit, one tap per cycle, fed by the line store and weight table read
// ports, then drains the MAC pipeline and loads the result register; the
// input is not taken again until the result is loaded, so a new compute
// request is accepted only after the last one is finished.
// Result channel (m_valid/m_ready) carries the clamped sample and its output
// position from an output register; a compute request with a position past
// the table produces no result. When the receiver stalls, the result holds
// and a new request may still be accepted; a following compute waits only
// at its last step until the output register is free.
// Reset (aresetn, synchronous, active low) clears the sequencer and the
// valid flags; the stores are not cleared and must be written before use.
// Depends on bfr_pkg, bfr_ram and bfr_mac.
`timescale 1ns / 1ps
`default_nettype none

module bicubic_fixed_point_resample import bfr_pkg::*; #(
    parameter int unsigned MAX_LINE      = 4096,
    parameter int unsigned MAX_OUT       = 2048,
    parameter int unsigned MAX_TAPS      = 16,
    parameter int unsigned FRACTION_BITS = 22
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic        [1:0]        s_func,
    input  wire logic        [LPOS_W-1:0] s_pixel_pos,
    input  wire logic        [PIX_W-1:0]  s_pixel_value,
    input  wire logic        [OPOS_W-1:0] s_out_pos,
    input  wire logic        [LPOS_W-1:0] s_window_start,
    input  wire logic        [CNT_W-1:0]  s_window_count,
    input  wire logic        [TAPP_W-1:0] s_tap_pos,
    input  wire logic signed [WGT_W-1:0]  s_weight,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic             [PIX_W-1:0]  m_out_pixel,
    output logic             [OPOS_W-1:0] m_result_pos
);

    localparam int unsigned LINE_AW = $clog2(MAX_LINE);
    localparam int unsigned OUT_AW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int unsigned WT_AW   = $clog2(MAX_OUT * MAX_TAPS);
    localparam int unsigned TAP_W   = $clog2(MAX_TAPS + 1);

    state_t state_reg, state_next;

    logic [OPOS_W-1:0] pos_reg, pos_next;
    logic [LPOS_W-1:0] start_reg, start_next;
    logic [TAP_W-1:0]  count_reg, count_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [WT_AW-1:0]  base_reg, base_next;
    logic              drain_reg, drain_next;
    logic              issue_reg, issue_next;
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  pixel_reg, pixel_next;

    logic accept;
    logic out_ok;
    logic func_pixel, func_window, func_weight, func_compute;
    logic out_free;

    logic [SRC_W-1:0]  src;
    logic              src_ok;
    logic [CNT_W-1:0]  win_count;

    logic               line_we, win_we, wt_we;
    logic               line_re, win_re, wt_re;
    logic [LINE_AW-1:0] line_waddr, line_raddr;
    logic [OUT_AW-1:0]  win_waddr, win_raddr;
    logic [WT_AW-1:0]   wt_waddr, wt_raddr;
    logic [PIX_W-1:0]   line_rdata;
    logic [WIN_W-1:0]   win_rdata;
    logic [WGT_W-1:0]   wt_rdata;

    mac_ctrl_t        mac_ctrl;
    logic [PIX_W-1:0] mac_sample;

    assign accept       = s_valid && s_ready;
    assign out_ok       = 32'(s_out_pos) < 32'(MAX_OUT);
    assign func_pixel   = func_t'(s_func) == FUNC_PIXEL;
    assign func_window  = func_t'(s_func) == FUNC_WINDOW;
    assign func_weight  = func_t'(s_func) == FUNC_WEIGHT;
    assign func_compute = func_t'(s_func) == FUNC_COMPUTE;
    assign out_free     = !m_valid_reg || m_ready;

    assign src       = SRC_W'(start_reg) + SRC_W'(tap_reg);
    assign src_ok    = 32'(src) < 32'(MAX_LINE);
    assign win_count = win_rdata[WIN_W-1:LPOS_W];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && func_compute && out_ok) begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                if (count_next == '0) begin
                    state_next = ST_DRAIN;
                end else begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP: begin
                if (tap_reg == count_reg - TAP_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready      = state_reg == ST_IDLE;
        pos_next     = pos_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        tap_next     = tap_reg;
        base_next    = base_reg;
        drain_next   = 1'b0;
        issue_next   = 1'b0;
        pixel_next   = pixel_reg;
        m_valid_next = m_valid_reg && !m_ready;

        line_we    = accept && func_pixel && (32'(s_pixel_pos) < 32'(MAX_LINE));
        line_waddr = LINE_AW'(s_pixel_pos);
        win_we     = accept && func_window && out_ok;
        win_waddr  = OUT_AW'(s_out_pos);
        wt_we      = accept && func_weight && out_ok && (32'(s_tap_pos) < 32'(MAX_TAPS));
        wt_waddr   = WT_AW'(WT_AW'(s_out_pos) * WT_AW'(MAX_TAPS)) + WT_AW'(s_tap_pos);

        win_re     = accept && func_compute && out_ok;
        win_raddr  = OUT_AW'(s_out_pos);
        line_re    = 1'b0;
        line_raddr = LINE_AW'(src);
        wt_re      = 1'b0;
        wt_raddr   = base_reg + WT_AW'(tap_reg);

        mac_ctrl.clear     = 1'b0;
        mac_ctrl.tap_valid = issue_reg;

        case (state_reg)
            ST_IDLE: begin
                if (win_re) begin
                    pos_next = s_out_pos;
                end
            end
            ST_WIN: begin
                start_next = win_rdata[LPOS_W-1:0];
                if (32'(win_count) > 32'(MAX_TAPS)) begin
                    count_next = TAP_W'(MAX_TAPS);
                end else begin
                    count_next = TAP_W'(win_count);
                end
                tap_next       = '0;
                base_next      = WT_AW'(WT_AW'(pos_reg) * WT_AW'(MAX_TAPS));
                mac_ctrl.clear = 1'b1;
            end
            ST_TAP: begin
                // taps past the end of the line contribute nothing
                line_re    = src_ok;
                wt_re      = src_ok;
                issue_next = src_ok;
                tap_next   = tap_reg + TAP_W'(1);
            end
            ST_DRAIN: begin
                drain_next = !drain_reg;
            end
            ST_FIN: begin
                if (out_free) begin
                    pixel_next   = mac_sample;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            drain_reg   <= 1'b0;
            issue_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            drain_reg   <= drain_next;
            issue_reg   <= issue_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        start_reg <= start_next;
        count_reg <= count_next;
        tap_reg   <= tap_next;
        base_reg  <= base_next;
        pixel_reg <= pixel_next;
    end

    // result position follows the output register with the sample
    logic [OPOS_W-1:0] rpos_reg, rpos_next;

    always_comb begin
        rpos_next = rpos_reg;
        if (state_reg == ST_FIN && out_free) begin
            rpos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rpos_reg <= rpos_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_pixel  = pixel_reg;
    assign m_result_pos = rpos_reg;

    bfr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (s_pixel_value),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    bfr_ram #(
        .WIDTH (WIN_W),
        .DEPTH (MAX_OUT)
    ) u_window_table (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata ({s_window_count, s_window_start}),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    bfr_ram #(
        .WIDTH (WGT_W),
        .DEPTH (MAX_OUT * MAX_TAPS)
    ) u_weight_table (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (s_weight),
        .re    (wt_re),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    bfr_mac #(
        .MAX_TAPS      (MAX_TAPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .pixel   (line_rdata),
        .weight  ($signed(wt_rdata)),
        .sample  (mac_sample)
    );

endmodule

`default_nettype wire

// ===== design/bfr_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data appears in the cycle after the read enable. Uses no package.
`timescale 1ns / 1ps
`default_nettype none

module bfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bfr_mac.sv =====
// Multiply-accumulate unit: registered product, then accumulate, then clamp.
// Depends on bfr_pkg for field widths and the control bundle.
`timescale 1ns / 1ps
`default_nettype none

module bfr_mac import bfr_pkg::*; #(
    parameter int unsigned MAX_TAPS      = 16,
    parameter int unsigned FRACTION_BITS = 22
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire mac_ctrl_t               ctrl,
    input  wire logic        [PIX_W-1:0] pixel,
    input  wire logic signed [WGT_W-1:0] weight,
    output logic             [PIX_W-1:0] sample
);

    localparam int unsigned ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(1) << (FRACTION_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
        prod_next = $signed({1'b0, pixel}) * weight;
        acc_next  = acc_reg;
        if (ctrl.clear) begin
            acc_next = BIAS;
        end else if (prod_valid_reg) begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= ctrl.tap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // floor shift by the fraction bits, then saturate to the pixel range
    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            sample = '0;
        end else if (|acc_reg[ACC_W-2:FRACTION_BITS+PIX_W]) begin
            sample = PIX_MAX;
        end else begin
            sample = acc_reg[FRACTION_BITS+PIX_W-1:FRACTION_BITS];
        end
    end

endmodule

`default_nettype wire
